// ===== sv/gpws_pkg.sv =====
// Package: shared types, codes and constants of the gated pulse wind-speed meter.
package gpws_pkg;

  // Default parameter values
  localparam int COUNT_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // Field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_W     = 32;
  localparam int COEF_W     = 32;
  localparam int MPS_W      = 16;
  localparam int KMPH_W     = 18;
  localparam int TOTAL_W    = 16;
  localparam int THR_W      = 16;

  // Multiplier operand width (one sign bit over a 32-bit magnitude) and product width
  localparam int MUL_OP_W   = 33;
  localparam int MUL_PROD_W = 2 * MUL_OP_W;
  localparam int NSQ_W      = 64;

  // Polynomial accumulator: coefficient times count squared plus headroom
  localparam int ACC_W      = 100;

  // km/h = (mps*36 + 5) / 10; the divide by ten is a multiply by ceil(2^25/10)
  localparam int               KMPH_X_W    = 22;
  localparam logic [KMPH_X_W-1:0] KMPH_RECIP = 22'd3355444;
  localparam int               KMPH_SHIFT  = 25;
  localparam int               KMPH_PROD_W = 2 * KMPH_X_W;

  // Register reset values
  localparam logic [TICK_W-1:0]        WINDOW_RST    = 32'd10000000;
  localparam logic signed [COEF_W-1:0] COEF_SQ_RST   = -32'sd3037;
  localparam logic signed [COEF_W-1:0] COEF_LIN_RST  = 32'sd2325127;
  localparam logic signed [COEF_W-1:0] COEF_OFF_RST  = 32'sd23580378;
  localparam logic [THR_W-1:0]         THRESHOLD_RST = 16'd384;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW    = 3'd0,
    REG_COEF_SQ   = 3'd1,
    REG_COEF_LIN  = 3'd2,
    REG_COEF_OFF  = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_t;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_NN   = 2'd0,
    MUL_A_LO = 2'd1,
    MUL_A_HI = 2'd2,
    MUL_B    = 2'd3
  } mul_op_t;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_INIT    = 2'd1,
    ACC_ADD     = 2'd2,
    ACC_ADD_HI  = 2'd3
  } acc_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    count_en;
    logic    mul_en;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    nsq_load;
    logic    round_en;
    logic    kmul_en;
    logic    out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic window_end;
    logic out_busy;
  } status_t;

endpackage

// ===== sv/gpws_if.sv =====
// Interfaces: sample input channel, result output channel and register write channel.
interface gpws_in_if;
  logic valid;
  logic ready;
  logic pulse_edge;
  logic tick;
  modport source (output valid, output pulse_edge, output tick, input ready);
  modport sink   (input valid, input pulse_edge, input tick, output ready);
endinterface

interface gpws_out_if;
  logic                            valid;
  logic                            ready;
  logic [gpws_pkg::MPS_W-1:0]      wind_mps;
  logic [gpws_pkg::KMPH_W-1:0]     wind_kmh;
  logic [gpws_pkg::TOTAL_W-1:0]    pulse_total;
  modport source (output valid, output wind_mps, output wind_kmh, output pulse_total,
                  input ready);
  modport sink   (input valid, input wind_mps, input wind_kmh, input pulse_total,
                  output ready);
endinterface

interface gpws_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gpws_pkg::CFG_IDX_W-1:0]   index;
  logic [gpws_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/gpws_ctrl.sv =====
// Controller: state machine that sequences counting, polynomial evaluation and result load.
module gpws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  gpws_pkg::status_t  sts,
  output logic               in_ready,
  output gpws_pkg::cmd_t     cmd
);

  typedef enum logic [9:0] {
    S_COUNT   = 10'b0000000001,
    S_SQ      = 10'b0000000010,
    S_NSQ     = 10'b0000000100,
    S_MUL_ALO = 10'b0000001000,
    S_ACC_ALO = 10'b0000010000,
    S_ACC_AHI = 10'b0000100000,
    S_ACC_B   = 10'b0001000000,
    S_ROUND   = 10'b0010000000,
    S_KMUL    = 10'b0100000000,
    S_LOAD    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = gpws_pkg::MUL_NN;
    cmd.acc_op = gpws_pkg::ACC_HOLD;
    case (state)
      S_COUNT: begin
        cmd.count_en = in_valid;
        if (in_valid && sts.window_end) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpws_pkg::MUL_NN;
        state_next = S_NSQ;
      end
      S_NSQ: begin
        cmd.nsq_load = 1'b1;
        cmd.acc_op   = gpws_pkg::ACC_INIT;
        state_next   = S_MUL_ALO;
      end
      S_MUL_ALO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpws_pkg::MUL_A_LO;
        state_next = S_ACC_ALO;
      end
      S_ACC_ALO: begin
        // add the low partial product while the high one is formed
        cmd.acc_op = gpws_pkg::ACC_ADD;
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpws_pkg::MUL_A_HI;
        state_next = S_ACC_AHI;
      end
      S_ACC_AHI: begin
        cmd.acc_op = gpws_pkg::ACC_ADD_HI;
        cmd.mul_en = 1'b1;
        cmd.mul_op = gpws_pkg::MUL_B;
        state_next = S_ACC_B;
      end
      S_ACC_B: begin
        cmd.acc_op = gpws_pkg::ACC_ADD;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        state_next   = S_KMUL;
      end
      S_KMUL: begin
        cmd.kmul_en = 1'b1;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_COUNT;
        end
      end
      default: begin
        state_next = S_COUNT;
      end
    endcase
  end

  a_end_starts_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT && in_valid && sts.window_end) |=> (state == S_SQ))
    else $error("window end did not start evaluation");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over an untaken result");

endmodule

// ===== sv/gpws_dp.sv =====
// Datapath: counters, configuration registers, shared multiplier, accumulator and result register.
module gpws_dp #(
  parameter int COUNT_WIDTH    = gpws_pkg::COUNT_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = gpws_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gpws_pkg::cmd_t                   cmd,
  output gpws_pkg::status_t                sts,
  input  logic                             pulse_edge,
  input  logic                             tick,
  input  logic                             cfg_valid,
  input  logic [gpws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gpws_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [gpws_pkg::MPS_W-1:0]       wind_mps,
  output logic [gpws_pkg::KMPH_W-1:0]      wind_kmh,
  output logic [gpws_pkg::TOTAL_W-1:0]     pulse_total
);

  localparam int SH    = COEF_FRAC_BITS - 8;
  localparam int ACC_W = gpws_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] HALF =
    (SH > 0) ? (ACC_W'(1) <<< ((SH > 0) ? (SH - 1) : 0)) : '0;

  // configuration
  logic [gpws_pkg::TICK_W-1:0]        window_ticks;
  logic signed [gpws_pkg::COEF_W-1:0] coef_square;
  logic signed [gpws_pkg::COEF_W-1:0] coef_linear;
  logic signed [gpws_pkg::COEF_W-1:0] coef_offset;
  logic [gpws_pkg::THR_W-1:0]         low_threshold;

  // counters
  logic [COUNT_WIDTH-1:0]      pulse_count;
  logic [COUNT_WIDTH-1:0]      pulse_count_next;
  logic [gpws_pkg::TICK_W-1:0] elapsed_ticks;
  logic [gpws_pkg::TICK_W:0]   tick_sum;
  logic [COUNT_WIDTH-1:0]      n_hold;
  logic [31:0]                 n32;

  // evaluation
  logic signed [gpws_pkg::MUL_OP_W-1:0]   mul_a;
  logic signed [gpws_pkg::MUL_OP_W-1:0]   mul_b;
  logic signed [gpws_pkg::MUL_PROD_W-1:0] prod;
  logic [gpws_pkg::NSQ_W-1:0]             nsq;
  logic signed [ACC_W-1:0]                acc;
  logic                                   acc_neg;
  logic                                   acc_big;
  logic [gpws_pkg::MPS_W-1:0]             acc_frac;
  logic [gpws_pkg::MPS_W-1:0]             mps;
  logic [gpws_pkg::KMPH_X_W-1:0]          kmph_x;
  logic [gpws_pkg::KMPH_PROD_W-1:0]       kprod;
  logic                                   out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks  <= gpws_pkg::WINDOW_RST;
      coef_square   <= gpws_pkg::COEF_SQ_RST;
      coef_linear   <= gpws_pkg::COEF_LIN_RST;
      coef_offset   <= gpws_pkg::COEF_OFF_RST;
      low_threshold <= gpws_pkg::THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (gpws_pkg::cfg_reg_t'(cfg_index))
        gpws_pkg::REG_WINDOW:    window_ticks  <= cfg_data;
        gpws_pkg::REG_COEF_SQ:   coef_square   <= cfg_data;
        gpws_pkg::REG_COEF_LIN:  coef_linear   <= cfg_data;
        gpws_pkg::REG_COEF_OFF:  coef_offset   <= cfg_data;
        gpws_pkg::REG_THRESHOLD: low_threshold <= cfg_data[gpws_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating pulse count; window closes on the tick that reaches the length
  assign pulse_count_next = (pulse_edge && !(&pulse_count)) ?
                            pulse_count + COUNT_WIDTH'(1) : pulse_count;
  assign tick_sum         = {1'b0, elapsed_ticks} + (gpws_pkg::TICK_W + 1)'(1);
  assign sts.window_end   = tick && (tick_sum >= {1'b0, window_ticks});

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count   <= '0;
      elapsed_ticks <= '0;
    end else if (cmd.count_en) begin
      if (sts.window_end) begin
        pulse_count   <= '0;
        elapsed_ticks <= '0;
      end else begin
        pulse_count <= pulse_count_next;
        if (tick) begin
          elapsed_ticks <= tick_sum[gpws_pkg::TICK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count_en && sts.window_end) begin
      n_hold <= pulse_count_next;
    end
  end

  assign n32 = 32'(n_hold);

  // shared signed 33x33 multiplier, operands by step
  always_comb begin
    case (cmd.mul_op)
      gpws_pkg::MUL_NN: begin
        mul_a = {1'b0, n32};
        mul_b = {1'b0, n32};
      end
      gpws_pkg::MUL_A_LO: begin
        mul_a = gpws_pkg::MUL_OP_W'(coef_square);
        mul_b = {1'b0, nsq[31:0]};
      end
      gpws_pkg::MUL_A_HI: begin
        mul_a = gpws_pkg::MUL_OP_W'(coef_square);
        mul_b = {1'b0, nsq[63:32]};
      end
      gpws_pkg::MUL_B: begin
        mul_a = gpws_pkg::MUL_OP_W'(coef_linear);
        mul_b = {1'b0, n32};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.nsq_load) begin
      nsq <= prod[gpws_pkg::NSQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      gpws_pkg::ACC_INIT:   acc <= ACC_W'(coef_offset) + HALF;
      gpws_pkg::ACC_ADD:    acc <= acc + ACC_W'(prod);
      gpws_pkg::ACC_ADD_HI: acc <= acc + (ACC_W'(prod) <<< 32);
      default: ;
    endcase
  end

  // round to Q8.8, clamp negatives and low speeds to zero, saturate large ones
  assign acc_neg  = acc[ACC_W-1];
  assign acc_big  = |acc[ACC_W-2:16+SH];
  assign acc_frac = acc[SH+15:SH];
  assign kmph_x   = ({6'b0, mps} << 5) + ({6'b0, mps} << 2) + gpws_pkg::KMPH_X_W'(5);

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      if (acc_neg) begin
        mps <= '0;
      end else if (acc_big) begin
        mps <= '1;
      end else if (acc_frac <= low_threshold) begin
        mps <= '0;
      end else begin
        mps <= acc_frac;
      end
    end
    if (cmd.kmul_en) begin
      kprod <= gpws_pkg::KMPH_PROD_W'(kmph_x) * gpws_pkg::KMPH_PROD_W'(gpws_pkg::KMPH_RECIP);
    end
  end

  // result register
  assign out_take     = out_valid && out_ready;
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      wind_mps    <= mps;
      wind_kmh    <= kprod[gpws_pkg::KMPH_SHIFT +: gpws_pkg::KMPH_W];
      pulse_total <= (|n32[31:16]) ? '1 : n32[15:0];
    end
  end

  a_window_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.count_en && sts.window_end) |=> (pulse_count == '0 && elapsed_ticks == '0))
    else $error("counters not cleared at window end");

  a_kmph_tracks_mps: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((wind_mps == '0) == (wind_kmh == '0)))
    else $error("km/h and m/s disagree on zero speed");

endmodule

// ===== sv/gated_pulse_wind_speed.sv =====
// Top level: gated pulse-count wind-speed meter with polynomial calibration.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid/ready      pulse_edge, tick (one clock sample per item)
//   out_ch   out  valid/ready      wind_mps Q8.8, wind_kmh Q10.8, pulse_total
//   cfg      in   valid/ready      index (register 0..4), data (32 bit)
//
// While counting, one sample item is taken every cycle. The item whose tick
// closes the gate window starts an evaluation on one shared 33x33 multiplier
// (n*n, a*n^2 in two halves, b*n, then rounding and km/h); the result turns
// valid when it is loaded into the output register. Input stays stalled during
// the evaluation and for as long as the previous result waits untaken in the
// output register. Reset is synchronous: counters clear, registers take their
// defaults. Register writes are always accepted.
module gated_pulse_wind_speed #(
  parameter int COUNT_WIDTH    = gpws_pkg::COUNT_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = gpws_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gpws_in_if.sink    in_ch,
  gpws_out_if.source out_ch,
  gpws_cfg_if.sink   cfg
);

  gpws_pkg::cmd_t    cmd;
  gpws_pkg::status_t sts;

  // register writes never stall
  assign cfg.ready = 1'b1;

  // sequence: count, evaluate the polynomial, load the result
  gpws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // counters, coefficients, arithmetic and the output register
  gpws_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .pulse_edge  (in_ch.pulse_edge),
    .tick        (in_ch.tick),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .wind_mps    (out_ch.wind_mps),
    .wind_kmh    (out_ch.wind_kmh),
    .pulse_total (out_ch.pulse_total)
  );

endmodule
